@@ rtl/nms_pkg.sv @@
// ----------------------------------------------------------------------------
// nms_pkg
// Shared types and constants of the greedy box suppression block.
// ----------------------------------------------------------------------------
package nms_pkg;

    localparam int MAX_KEPT = 64;
    localparam int ADDR_W   = $clog2(MAX_KEPT);
    localparam int CNT_W    = $clog2(MAX_KEPT + 1);

    localparam int COORD_W = 16;
    localparam int SIZE_W  = 15;
    localparam int AREA_W  = 2 * SIZE_W;
    localparam int THR_W   = 16;
    localparam int POS_W   = 16;

    localparam logic [CNT_W-1:0] MAX_KEPT_CNT = CNT_W'(MAX_KEPT);
    localparam logic [THR_W-1:0] THR_RESET    = 16'd29491;
    localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};

    // One stored box with its area.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [SIZE_W-1:0]         w;
        logic [SIZE_W-1:0]         h;
        logic [AREA_W-1:0]         area;
    } kept_entry_t;

    localparam int ENTRY_W = $bits(kept_entry_t);

    // Status from the overlap pipeline back to the sequencer.
    typedef struct packed {
        logic busy;
        logic hit;
    } iou_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

endpackage

@@ rtl/nms_ifs.sv @@
// ----------------------------------------------------------------------------
// nms_ifs
// Valid/ready channels for incoming boxes and for suppression results.
// ----------------------------------------------------------------------------
interface nms_box_if;
    logic        valid;
    logic        ready;
    logic        frame_start;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic [14:0] box_w;
    logic [14:0] box_h;

    modport source (output valid, frame_start, box_x, box_y, box_w, box_h, input ready);
    modport sink   (input valid, frame_start, box_x, box_y, box_w, box_h, output ready);
endinterface

interface nms_res_if;
    logic        valid;
    logic        ready;
    logic        keep;
    logic [15:0] position;
    logic        overflow;

    modport source (output valid, keep, position, overflow, input ready);
    modport sink   (input valid, keep, position, overflow, output ready);
endinterface

@@ rtl/nms_ram.sv @@
// ----------------------------------------------------------------------------
// nms_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/nms_iou.sv @@
// ----------------------------------------------------------------------------
// nms_iou
// Pipelined overlap test of the current box against one stored box per cycle.
// ----------------------------------------------------------------------------
module nms_iou import nms_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_issue,
    input  kept_entry_t       cur,
    input  kept_entry_t       kept,
    input  logic [THR_W-1:0]  thr,
    output iou_stat_t         stat
);

    // Valid flags: v0 marks RAM data, v1..v4 the registered stages.
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;

    logic [SIZE_W-1:0]   dx_reg, dx_next, dy_reg, dy_next;
    logic [AREA_W-1:0]   karea1_reg, karea2_reg;
    logic [AREA_W-1:0]   inter2_reg, inter2_next, inter3_reg, inter4_reg;
    logic [AREA_W:0]     uni_reg, uni_next;
    logic [AREA_W+THR_W:0] prod_reg, prod_next;

    logic signed [COORD_W+1:0] cur_r, cur_b, kept_r, kept_b;
    logic signed [COORD_W+1:0] left, top, right, bottom, span_x, span_y;

    always_comb
    begin
        cur_r  = 18'(cur.x) + 18'(signed'({3'b000, cur.w}));
        cur_b  = 18'(cur.y) + 18'(signed'({3'b000, cur.h}));
        kept_r = 18'(kept.x) + 18'(signed'({3'b000, kept.w}));
        kept_b = 18'(kept.y) + 18'(signed'({3'b000, kept.h}));
        left   = (cur.x > kept.x) ? 18'(cur.x) : 18'(kept.x);
        top    = (cur.y > kept.y) ? 18'(cur.y) : 18'(kept.y);
        right  = (cur_r < kept_r) ? cur_r : kept_r;
        bottom = (cur_b < kept_b) ? cur_b : kept_b;
        span_x = right - left;
        span_y = bottom - top;
        // A positive span never exceeds the narrower box, so it fits the size width.
        if (span_x > 18'sd0 && span_y > 18'sd0)
        begin
            dx_next = span_x[SIZE_W-1:0];
            dy_next = span_y[SIZE_W-1:0];
        end
        else
        begin
            dx_next = '0;
            dy_next = '0;
        end
        inter2_next = AREA_W'(dx_reg) * AREA_W'(dy_reg);
        uni_next    = {1'b0, cur.area} + {1'b0, karea2_reg} - {1'b0, inter2_reg};
        prod_next   = (AREA_W+THR_W+1)'(thr) * (AREA_W+THR_W+1)'(uni_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= rd_issue;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        karea1_reg <= kept.area;
        karea2_reg <= karea1_reg;
        inter2_reg <= inter2_next;
        inter3_reg <= inter2_reg;
        inter4_reg <= inter3_reg;
        uni_reg    <= uni_next;
        prod_reg   <= prod_next;
    end

    assign stat.busy = v0_reg | v1_reg | v2_reg | v3_reg | v4_reg;
    assign stat.hit  = v4_reg && ({1'b0, inter4_reg, {THR_W{1'b0}}} > prod_reg);

endmodule

@@ rtl/greedy_box_nms.sv @@
// ----------------------------------------------------------------------------
// greedy_box_nms
// Greedy non-maximum suppression over boxes sorted by descending score.
// ----------------------------------------------------------------------------
// Boxes arrive on the "boxes" valid/ready channel, one item at a time; each
// item yields exactly one item on the "results" channel with the keep flag,
// the position since frame start and the overflow flag. The threshold is
// written through cfg_we/cfg_wdata; the user must do so only while the block
// is idle, as the block itself does not enforce it. For each item the stored
// boxes are read from the box RAM one per cycle and streamed through the
// overlap pipeline, then the pipeline drains and the surviving box is written
// back, up to a full store of 64 boxes. The result sits in an output
// register, so the next item is accepted while it waits; if the receiver
// stalls, the following item stops at its final step until the register
// frees. Reset empties the kept list, zeroes the position count and loads
// the threshold with 0.45 in Q0.16. The RAM needs no clearing, since only
// entries below the kept count are read.
// ----------------------------------------------------------------------------
module greedy_box_nms import nms_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    nms_box_if.sink          boxes,
    nms_res_if.source        results,
    input  logic             cfg_we,
    input  logic [THR_W-1:0] cfg_wdata
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  item_pos_reg, item_pos_next;
    logic [THR_W-1:0]  thr_reg, thr_next;
    logic              keep_reg, keep_next;
    kept_entry_t       cur_reg, cur_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_keep_reg, out_keep_next;
    logic [POS_W-1:0]  out_pos_reg, out_pos_next;
    logic              out_ovf_reg, out_ovf_next;

    logic              accept;
    logic [POS_W-1:0]  pos_now;
    logic              rd_en, wr_en;
    kept_entry_t       rd_data;
    iou_stat_t         iou_stat;

    nms_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_KEPT)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (cur_reg),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    nms_iou u_iou (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_issue (rd_en),
        .cur      (cur_reg),
        .kept     (rd_data),
        .thr      (thr_reg),
        .stat     (iou_stat)
    );

    assign boxes.ready = (state_reg == ST_IDLE);
    assign accept      = boxes.valid && (state_reg == ST_IDLE);
    assign pos_now     = boxes.frame_start ? '0 : pos_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        item_pos_next  = item_pos_reg;
        thr_next       = cfg_we ? cfg_wdata : thr_reg;
        keep_next      = keep_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        out_keep_next  = out_keep_reg;
        out_pos_next   = out_pos_reg;
        out_ovf_next   = out_ovf_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cur_next.x    = boxes.box_x;
                    cur_next.y    = boxes.box_y;
                    cur_next.w    = boxes.box_w;
                    cur_next.h    = boxes.box_h;
                    cur_next.area = AREA_W'(boxes.box_w) * AREA_W'(boxes.box_h);
                    keep_next     = 1'b1;
                    idx_next      = '0;
                    item_pos_next = pos_now;
                    pos_next      = (pos_now == POS_MAX) ? pos_now : pos_now + 1'b1;
                    if (boxes.frame_start)
                    begin
                        count_next = '0;
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg < count_reg)
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!iou_stat.busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next = 1'b1;
                    out_keep_next  = keep_reg;
                    out_pos_next   = item_pos_reg;
                    out_ovf_next   = keep_reg && (count_reg == MAX_KEPT_CNT);
                    if (keep_reg && (count_reg < MAX_KEPT_CNT))
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (iou_stat.hit)
        begin
            keep_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            thr_reg       <= THR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            thr_reg       <= thr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_pos_reg <= item_pos_next;
        keep_reg     <= keep_next;
        cur_reg      <= cur_next;
        out_keep_reg <= out_keep_next;
        out_pos_reg  <= out_pos_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign results.valid    = out_valid_reg;
    assign results.keep     = out_keep_reg;
    assign results.position = out_pos_reg;
    assign results.overflow = out_ovf_reg;

endmodule

@@ dv/greedy_box_nms_check.sv @@
// ----------------------------------------------------------------------------
// greedy_box_nms_check
// Watches the box and result channels and predicts every suppression verdict.
// ----------------------------------------------------------------------------
// Each box accepted on the input channel is judged against a private copy of
// the kept list and the threshold, and the verdict is queued. Each accepted
// result is compared field by field with the oldest queued verdict. The
// failure count, the number of results checked and the number of verdicts
// still due go back to the top.
module greedy_box_nms_check import nms_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    nms_box_if               boxes,
    nms_res_if               results,
    input  logic             cfg_we,
    input  logic [THR_W-1:0] cfg_wdata,
    output int               failures,
    output int               pending,
    output int               checked
);

    typedef struct packed {
        logic             keep;
        logic [POS_W-1:0] position;
        logic             overflow;
    } verdict_t;

    verdict_t         due_verdicts[$];
    kept_entry_t      survivors[MAX_KEPT];
    int               survivor_count;
    logic [POS_W-1:0] next_position;
    logic [THR_W-1:0] threshold;

    function automatic void flag(input string msg);
        failures++;
        if (failures <= 10)
        begin
            $display("mismatch: %s", msg);
        end
    endfunction

    // Right and bottom edges need more than 16 bits, so the geometry is done in int.
    function automatic longint shared_area(input kept_entry_t a, input kept_entry_t b);
        int lo_x;
        int hi_x;
        int lo_y;
        int hi_y;
        lo_x = int'($signed(a.x));
        if (int'($signed(b.x)) > lo_x)
        begin
            lo_x = int'($signed(b.x));
        end
        hi_x = int'($signed(a.x)) + int'(a.w);
        if (int'($signed(b.x)) + int'(b.w) < hi_x)
        begin
            hi_x = int'($signed(b.x)) + int'(b.w);
        end
        lo_y = int'($signed(a.y));
        if (int'($signed(b.y)) > lo_y)
        begin
            lo_y = int'($signed(b.y));
        end
        hi_y = int'($signed(a.y)) + int'(a.h);
        if (int'($signed(b.y)) + int'(b.h) < hi_y)
        begin
            hi_y = int'($signed(b.y)) + int'(b.h);
        end
        if (hi_x <= lo_x || hi_y <= lo_y)
        begin
            return 0;
        end
        return longint'(hi_x - lo_x) * longint'(hi_y - lo_y);
    endfunction

    function automatic verdict_t judge_box(input logic fs,
                                           input logic [COORD_W-1:0] x,
                                           input logic [COORD_W-1:0] y,
                                           input logic [SIZE_W-1:0] w,
                                           input logic [SIZE_W-1:0] h);
        kept_entry_t cand;
        verdict_t    v;
        longint      inter;
        longint      uni;
        if (fs)
        begin
            survivor_count = 0;
            next_position  = '0;
        end
        cand.x    = x;
        cand.y    = y;
        cand.w    = w;
        cand.h    = h;
        cand.area = AREA_W'(w) * AREA_W'(h);
        v.keep     = 1'b1;
        v.overflow = 1'b0;
        for (int i = 0; i < survivor_count; i++)
        begin
            inter = shared_area(cand, survivors[i]);
            uni   = longint'(cand.area) + longint'(survivors[i].area) - inter;
            // IoU above threshold, cross-multiplied to avoid the division.
            if (inter * 65536 > longint'(threshold) * uni)
            begin
                v.keep = 1'b0;
            end
        end
        if (v.keep)
        begin
            if (survivor_count < MAX_KEPT)
            begin
                survivors[survivor_count] = cand;
                survivor_count++;
            end
            else
            begin
                v.overflow = 1'b1;
            end
        end
        v.position = next_position;
        if (next_position != POS_MAX)
        begin
            next_position++;
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t got;
        verdict_t want;
        if (!rst_n)
        begin
            due_verdicts.delete();
            survivor_count = 0;
            next_position  = '0;
            threshold      = THR_RESET;
            failures       = 0;
            pending        = 0;
            checked        = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                threshold = cfg_wdata;
            end
            if (results.valid && results.ready)
            begin
                got.keep     = results.keep;
                got.position = results.position;
                got.overflow = results.overflow;
                checked++;
                if (due_verdicts.size() == 0)
                begin
                    flag($sformatf("result %0d arrived with none due (keep %0d position %0d)",
                                   checked, got.keep, got.position));
                end
                else
                begin
                    want = due_verdicts.pop_front();
                    if (got.keep !== want.keep)
                    begin
                        flag($sformatf("result %0d keep: expected %0d, got %0d",
                                       checked, want.keep, got.keep));
                    end
                    if (got.position !== want.position)
                    begin
                        flag($sformatf("result %0d position: expected %0d, got %0d",
                                       checked, want.position, got.position));
                    end
                    if (got.overflow !== want.overflow)
                    begin
                        flag($sformatf("result %0d overflow: expected %0d, got %0d",
                                       checked, want.overflow, got.overflow));
                    end
                end
            end
            if (boxes.valid && boxes.ready)
            begin
                due_verdicts.insert(due_verdicts.size(),
                                    judge_box(boxes.frame_start, boxes.box_x,
                                              boxes.box_y, boxes.box_w, boxes.box_h));
            end
            pending = due_verdicts.size();
        end
    end

endmodule

@@ dv/greedy_box_nms_test.sv @@
// ----------------------------------------------------------------------------
// greedy_box_nms_test
// Stimulus and verdict for the greedy box suppression block.
// ----------------------------------------------------------------------------
// Directed boxes hit the geometric corners, the threshold extremes and a full
// store; random frames of clustered, crowded and noisy boxes follow under
// several thresholds. Both channels idle at random, and once the receiver
// holds off long enough to back the block up. The checker beside the block
// predicts and compares.
// ----------------------------------------------------------------------------
module greedy_box_nms_test;
    import nms_pkg::*;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int QUIET_LIMIT     = 4000;
    localparam int BLOCK_ITEMS     = 80;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [THR_W-1:0] cfg_wdata;
    bit               gaps_on;
    bit               stalls_on;
    bit               hold_off_req;
    int               failures;
    int               pending;
    int               checked;
    int               random_items;

    nms_box_if boxes();
    nms_res_if results();

    greedy_box_nms i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .boxes     (boxes),
        .results   (results),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    greedy_box_nms_check i_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .boxes     (boxes),
        .results   (results),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .failures  (failures),
        .pending   (pending),
        .checked   (checked)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Offer one item and return at the falling edge after it is accepted.
    // Valid stays high so that back-to-back items need no toggle.
    task automatic offer_box(input logic fs, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [SIZE_W-1:0] w,
                             input logic [SIZE_W-1:0] h);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            boxes.valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        boxes.valid       = 1'b1;
        boxes.frame_start = fs;
        boxes.box_x       = x;
        boxes.box_y       = y;
        boxes.box_w       = w;
        boxes.box_h       = h;
        @(posedge clk);
        while (!boxes.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic settle();
        boxes.valid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic set_threshold(input logic [THR_W-1:0] value);
        settle();
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Mostly well-formed frames: clustered boxes that suppress each other,
    // crowded frames of small scattered boxes that overrun the store, and
    // some fully random items with random frame starts.
    task automatic run_frames(input int n_items);
        int                  sent;
        int                  mode;
        int                  len;
        int                  ncent;
        int                  k;
        int                  w0;
        logic [COORD_W-1:0]  cx[3];
        logic [COORD_W-1:0]  cy[3];
        sent = 0;
        while (sent < n_items)
        begin
            mode = $urandom_range(0, 9);
            if (mode == 0)
            begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                begin
                    offer_box(1'($urandom), 16'($urandom), 16'($urandom),
                              15'($urandom), 15'($urandom));
                end
            end
            else if (mode == 1)
            begin
                len = $urandom_range(60, 80);
                for (int i = 0; i < len; i++)
                begin
                    offer_box(i == 0, 16'($urandom), 16'($urandom),
                              15'($urandom_range(0, 64)), 15'($urandom_range(0, 64)));
                end
            end
            else
            begin
                len   = $urandom_range(1, 40);
                ncent = $urandom_range(1, 3);
                w0    = $urandom_range(16, 2048);
                for (int c = 0; c < 3; c++)
                begin
                    cx[c] = 16'($urandom);
                    cy[c] = 16'($urandom);
                end
                for (int i = 0; i < len; i++)
                begin
                    k = $urandom_range(0, ncent - 1);
                    offer_box(i == 0,
                              16'(int'(cx[k]) + int'($urandom_range(0, w0)) - w0 / 2),
                              16'(int'(cy[k]) + int'($urandom_range(0, w0)) - w0 / 2),
                              15'(w0 + int'($urandom_range(0, 64))),
                              15'(w0 + int'($urandom_range(0, 64))));
                end
            end
            sent = sent + len;
        end
        random_items = random_items + sent;
    endtask

    // Receiver: random bursts of back-pressure, plus one long hold-off on request.
    initial
    begin
        bit held;
        held          = 1'b0;
        results.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !held)
            begin
                results.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                held = 1'b1;
            end
            else if (stalls_on && $urandom_range(0, 3) == 0)
            begin
                results.ready = 1'b0;
                repeat ($urandom_range(0, 14)) @(negedge clk);
            end
            else
            begin
                results.ready = 1'b1;
                repeat ($urandom_range(0, 20)) @(negedge clk);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((boxes.valid && boxes.ready) || (results.valid && results.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
        $display("FAIL greedy_box_nms");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        boxes.valid       = 1'b0;
        boxes.frame_start = 1'b0;
        boxes.box_x       = '0;
        boxes.box_y       = '0;
        boxes.box_w       = '0;
        boxes.box_h       = '0;
        gaps_on           = 1'b1;
        stalls_on         = 1'b1;
        hold_off_req      = 1'b0;
        random_items      = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Default threshold: identical, touching, disjoint, extreme and empty boxes.
        offer_box(1'b1, 16'sd0, 16'sd0, 15'd160, 15'd160);
        offer_box(1'b0, 16'sd0, 16'sd0, 15'd160, 15'd160);
        offer_box(1'b0, 16'sd160, 16'sd0, 15'd160, 15'd160);
        offer_box(1'b0, -16'sd32768, -16'sd32768, 15'd32767, 15'd32767);
        offer_box(1'b0, 16'sd32767, 16'sd32767, 15'd32767, 15'd32767);
        offer_box(1'b0, 16'sd0, 16'sd0, 15'd0, 15'd0);
        offer_box(1'b0, 16'sd0, 16'sd0, 15'd0, 15'd0);
        offer_box(1'b0, 16'sd80, 16'sd0, 15'd160, 15'd160);
        offer_box(1'b0, 16'sd16, 16'sd0, 15'd160, 15'd160);
        offer_box(1'b1, -16'sd16, -16'sd16, 15'd32, 15'd32);

        // Zero threshold: a single pixel of overlap suppresses.
        set_threshold(16'd0);
        offer_box(1'b1, 16'sd0, 16'sd0, 15'd100, 15'd100);
        offer_box(1'b0, 16'sd99, 16'sd99, 15'd100, 15'd100);
        offer_box(1'b0, 16'sd100, 16'sd0, 15'd50, 15'd50);
        offer_box(1'b0, 16'sd50, 16'sd50, 15'd0, 15'd0);

        // Largest threshold: only an exact duplicate is suppressed.
        set_threshold(16'd65535);
        offer_box(1'b1, 16'sd0, 16'sd0, 15'd320, 15'd320);
        offer_box(1'b0, 16'sd0, 16'sd0, 15'd320, 15'd320);
        offer_box(1'b0, 16'sd1, 16'sd1, 15'd320, 15'd320);

        // Full store: 64 disjoint boxes, one more that overflows, one duplicate.
        set_threshold(THR_RESET);
        for (int i = 0; i < MAX_KEPT + 1; i++)
        begin
            offer_box(i == 0, 16'(i * 64), 16'sd0, 15'd32, 15'd32);
        end
        offer_box(1'b0, 16'sd0, 16'sd0, 15'd32, 15'd32);

        set_threshold(16'($urandom));
        run_frames(BLOCK_ITEMS);
        set_threshold(16'd0);
        hold_off_req = 1'b1;
        run_frames(BLOCK_ITEMS);
        set_threshold(16'd65535);
        run_frames(BLOCK_ITEMS);
        set_threshold(16'($urandom_range(16384, 49152)));
        run_frames(BLOCK_ITEMS);
        set_threshold(THR_RESET);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        run_frames(BLOCK_ITEMS);

        settle();
        repeat (80) @(negedge clk);
        $display("covered %0d results: corner geometry, thresholds 0 and 65535 and a full store,",
                 checked);
        $display("then %0d random items in clustered, crowded and noisy frames",
                 random_items);
        if (failures == 0 && pending == 0)
        begin
            $display("PASS greedy_box_nms");
        end
        else
        begin
            $display("FAIL greedy_box_nms");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/nms_pkg.sv
rtl/nms_ifs.sv
rtl/nms_ram.sv
rtl/nms_iou.sv
rtl/greedy_box_nms.sv
dv/greedy_box_nms_check.sv
dv/greedy_box_nms_test.sv
